FILE: rtl/assert_macros.svh
// Assertion helpers for the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define SDC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same-cycle implication between an antecedent and a consequent.
`define SDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// Next-cycle implication between an antecedent and a consequent.
`define SDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/sdc_pkg.sv
package sdc_pkg;

    // Fixed widths of the request and result fields.
    localparam int REQ_W   = 2;
    localparam int VALUE_W = 16;
    localparam int START_W = 11;
    localparam int OUT_W   = 11;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_WIPE,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_CLEAN,
        ST_CLEAN_DRAIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_array;
        logic append;
        logic load_query;
        logic scan_issue;
        logic clean_load;
        logic clean_issue;
        logic emit_direct;
        logic emit_count;
        logic wipe_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_bad;
        logic in_past;
        logic at_first;
        logic scan_empty;
        logic clean_empty;
        logic wipe_last;
    } stat_t;

endpackage

FILE: rtl/sdc_datapath.sv
module sdc_datapath
    import sdc_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic [VALUE_W-1:0] element_value,
    input  logic [START_W-1:0] query_start,
    output stat_t              stat,
    output logic               done,
    output logic [OUT_W-1:0]   distinct_count,
    output logic               bad_start
);

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W = (CNT_W > START_W) ? CNT_W : START_W;
    localparam longint unsigned SEEN_LAST = (64'd1 << VALUE_BITS) - 64'd1;

    // Element store and the seen map indexed by value.
    logic [VALUE_BITS-1:0] elem_mem [MAX_ELEMENTS];
    logic                  seen_mem [0:SEEN_LAST];

    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      first_reg;
    logic [VALUE_BITS-1:0] elem_rd_reg;
    logic                  b_valid_reg;
    logic                  b_clean_reg;
    logic                  seen_rd_reg;
    logic [VALUE_BITS-1:0] c_val_reg;
    logic                  c_valid_reg;
    logic [VALUE_BITS-1:0] prev_val_reg;
    logic                  prev_valid_reg;
    logic [CNT_W-1:0]      tally_reg;
    logic [VALUE_BITS-1:0] wipe_addr_reg;
    logic                  done_reg;
    logic [OUT_W-1:0]      out_count_reg;
    logic                  out_bad_reg;

    logic [CMP_W-1:0]      start_ext;
    logic [CMP_W-1:0]      start_m1;
    logic                  store_full;
    logic [IDX_W-1:0]      last_idx;
    logic                  hit;
    logic                  seen_we;
    logic [VALUE_BITS-1:0] seen_wa;
    logic                  seen_wd;

    // Request decode against the current fill level.
    always_comb
    begin
        start_ext        = CMP_W'(query_start);
        start_m1         = start_ext - CMP_W'(1);
        store_full       = (count_reg == CNT_W'(MAX_ELEMENTS));
        last_idx         = IDX_W'(count_reg - CNT_W'(1));
        stat.in_bad      = (query_start == '0);
        stat.in_past     = (start_m1 >= CMP_W'(count_reg));
        stat.at_first    = (idx_reg == first_reg);
        stat.scan_empty  = !b_valid_reg && !c_valid_reg;
        stat.clean_empty = !b_valid_reg;
        stat.wipe_last   = &wipe_addr_reg;
    end

    // A value is new unless the map has it or the previous element, whose write the map read has not seen, had it too.
    assign hit = seen_rd_reg || (prev_valid_reg && (prev_val_reg == c_val_reg));

    // Seen map write port: reset wipe, clean-up pass or marking during the scan.
    always_comb
    begin
        seen_we = 1'b0;
        seen_wa = c_val_reg;
        seen_wd = 1'b1;
        if (cmd.wipe_step)
        begin
            seen_we = 1'b1;
            seen_wa = wipe_addr_reg;
            seen_wd = 1'b0;
        end
        else if (b_valid_reg && b_clean_reg)
        begin
            seen_we = 1'b1;
            seen_wa = elem_rd_reg;
            seen_wd = 1'b0;
        end
        else if (c_valid_reg)
        begin
            seen_we = 1'b1;
        end
    end

    // Element store: one write port for appends, registered read for the scans.
    always_ff @(posedge clk)
    begin
        if (cmd.append && !store_full)
        begin
            elem_mem[count_reg[IDX_W-1:0]] <= VALUE_BITS'(element_value);
        end
        if (cmd.scan_issue || cmd.clean_issue)
        begin
            elem_rd_reg <= elem_mem[idx_reg];
        end
    end

    // Seen map: one write port, registered read.
    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        if (b_valid_reg && !b_clean_reg)
        begin
            seen_rd_reg <= seen_mem[elem_rd_reg];
        end
    end

    // Scan pipeline payload.
    always_ff @(posedge clk)
    begin
        c_val_reg    <= elem_rd_reg;
        prev_val_reg <= c_val_reg;
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.emit_direct)
        begin
            out_count_reg <= '0;
            out_bad_reg   <= stat.in_bad;
        end
        else if (cmd.emit_count)
        begin
            out_count_reg <= OUT_W'(tally_reg);
            out_bad_reg   <= 1'b0;
        end
    end

    // Control state: fill level, scan index, pipeline valids, tally and wipe address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            first_reg      <= '0;
            b_valid_reg    <= 1'b0;
            b_clean_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            prev_valid_reg <= 1'b0;
            tally_reg      <= '0;
            wipe_addr_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.clear_array)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && !store_full)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end

            if (cmd.load_query)
            begin
                idx_reg   <= last_idx;
                first_reg <= IDX_W'(start_m1);
            end
            else if (cmd.clean_load)
            begin
                idx_reg <= last_idx;
            end
            else if (cmd.scan_issue || cmd.clean_issue)
            begin
                idx_reg <= idx_reg - IDX_W'(1);
            end

            b_valid_reg    <= cmd.scan_issue || cmd.clean_issue;
            b_clean_reg    <= cmd.clean_issue;
            c_valid_reg    <= b_valid_reg && !b_clean_reg;
            prev_valid_reg <= c_valid_reg;

            if (cmd.load_query)
            begin
                tally_reg <= '0;
            end
            else if (c_valid_reg && !hit)
            begin
                tally_reg <= tally_reg + CNT_W'(1);
            end

            if (cmd.wipe_step)
            begin
                wipe_addr_reg <= wipe_addr_reg + VALUE_BITS'(1);
            end

            done_reg <= cmd.emit_direct || cmd.emit_count;
        end
    end

    assign done           = done_reg;
    assign distinct_count = out_count_reg;
    assign bad_start      = out_bad_reg;

endmodule

FILE: rtl/sdc_ctrl.sv
module sdc_ctrl
    import sdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [REQ_W-1:0] req_type,
    input  stat_t            stat,
    output cmd_t             cmd,
    output logic             busy
);

    state_t state_reg;
    state_t state_next;

    // State register; reset starts the seen map wipe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_WIPE:
            begin
                cmd.wipe_step = 1'b1;
                if (stat.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_CLEAR:  cmd.clear_array = 1'b1;
                        REQ_APPEND: cmd.append      = 1'b1;
                        REQ_QUERY:
                        begin
                            if (stat.in_bad || stat.in_past)
                            begin
                                cmd.emit_direct = 1'b1;
                            end
                            else
                            begin
                                cmd.load_query = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.at_first)
                begin
                    state_next = ST_SCAN_DRAIN;
                end
            end
            ST_SCAN_DRAIN:
            begin
                if (stat.scan_empty)
                begin
                    cmd.emit_count = 1'b1;
                    cmd.clean_load = 1'b1;
                    state_next     = ST_CLEAN;
                end
            end
            ST_CLEAN:
            begin
                cmd.clean_issue = 1'b1;
                if (stat.at_first)
                begin
                    state_next = ST_CLEAN_DRAIN;
                end
            end
            ST_CLEAN_DRAIN:
            begin
                if (stat.clean_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: rtl/suffix_distinct_count_core.sv
// Clear and append requests finish on acceptance; a query with a zero start or a start
// past the end gives its result in the cycle after acceptance. A query over a suffix
// does one element store read per cycle in the scan and gives its result once the scan
// pipeline drains; busy stays high through a following clean-up pass that clears the
// seen map entries of the scanned elements. Reset is asynchronous; afterwards busy stays
// high while the seen map is wiped, one entry per cycle. Results are strobed on done.
module suffix_distinct_count_core
    import sdc_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [VALUE_W-1:0] element_value,
    input  logic [START_W-1:0] query_start,
    output logic               done,
    output logic [OUT_W-1:0]   distinct_count,
    output logic               bad_start
);

    cmd_t  cmd;
    stat_t stat;

    // Request sequencing.
    sdc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Storage, scan pipeline and result registers.
    sdc_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .element_value  (element_value),
        .query_start    (query_start),
        .stat           (stat),
        .done           (done),
        .distinct_count (distinct_count),
        .bad_start      (bad_start)
    );

endmodule

FILE: rtl/sdc_checker.sv
`include "assert_macros.svh"

module sdc_checker
    import sdc_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [REQ_W-1:0]   req_type,
    input logic               done,
    input logic [OUT_W-1:0]   distinct_count,
    input logic               bad_start
);

    // A result only follows an accepted request or work in progress.
    `SDC_ASSERT_IMPL(a_done_has_cause, clk, rst_n, done, $past(busy || start))

    // A zero start always reports an empty count.
    `SDC_ASSERT_IMPL(a_bad_is_zero, clk, rst_n, done && bad_start, distinct_count == '0)

    // Clear and append requests finish at once and give no result.
    `SDC_ASSERT_NEXT(a_short_req, clk, rst_n, start && !busy && (req_type != REQ_QUERY), !busy && !done)

    // The block only becomes busy on an accepted request.
    `SDC_ASSERT_IMPL(a_busy_rise, clk, rst_n, $rose(busy), $past(start))

    // A count never exceeds the store capacity.
    `SDC_ASSERT(a_count_range, clk, rst_n, !done || (distinct_count <= MAX_ELEMENTS))

endmodule

bind suffix_distinct_count_core sdc_checker #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_sdc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .done           (done),
    .distinct_count (distinct_count),
    .bad_start      (bad_start)
);
